### design/llex_pkg.sv
// Shared types, field widths and character constants for the s-expression token lexer.
`timescale 1ns / 1ps
`default_nettype none

package llex_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int LENGTH_BITS = 12;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    localparam logic [3:0] KIND_LPAREN = 4'd0;
    localparam logic [3:0] KIND_RPAREN = 4'd1;
    localparam logic [3:0] KIND_LBRACE = 4'd2;
    localparam logic [3:0] KIND_RBRACE = 4'd3;
    localparam logic [3:0] KIND_NUMBER = 4'd4;
    localparam logic [3:0] KIND_SYMBOL = 4'd5;
    localparam logic [3:0] KIND_STRING = 4'd6;
    localparam logic [3:0] KIND_END    = 4'd7;
    localparam logic [3:0] KIND_ERROR  = 4'd8;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNTERM_STR = 2'd1;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [3:0]             token_kind;
        logic [OFFSET_BITS-1:0] token_start;
        logic [LENGTH_BITS-1:0] token_length;
        logic [1:0]             error_code;
        logic                   run_last;
    } t_out_word;

    // One queue entry carries every token that a single input word produced.
    typedef struct packed {
        logic      two;
        t_out_word tok0;
        t_out_word tok1;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_symbyte(input logic [7:0] b);
        return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                          8'h21, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2B, 8'h2D, 8'h2F,
                          8'h3A, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5C, 8'h5E,
                          8'h5F, 8'h7E});
    endfunction

endpackage

`default_nettype wire

### design/llex_front.sv
// Front end: accepts source bytes, classifies them and keeps the lexer mode and pending token.
`timescale 1ns / 1ps
`default_nettype none

module llex_front import llex_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_word i_in_word,
    input  t_q_stat  i_q_stat,
    output logic     o_in_stall,
    output logic     o_push,
    output t_entry   o_entry
);

    typedef enum logic [5:0] {
        M_IDLE    = 6'b000001,
        M_COMMENT = 6'b000010,
        M_NUMBER  = 6'b000100,
        M_SYMBOL  = 6'b001000,
        M_STRING  = 6'b010000,
        M_STRESC  = 6'b100000
    } t_mode;

    t_mode                  r_mode, n_mode, il_mode;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_pstart, n_pstart;
    logic [LENGTH_BITS-1:0] r_plen, n_plen, plen_inc;
    logic                   accept, il_emit, il_begin, use_idle;
    logic                   f_valid, s_valid;
    t_out_word              il_tok, f_tok, s_tok;
    logic [7:0]             b;

    assign accept     = i_in_valid && !i_q_stat.full;
    assign o_in_stall = i_q_stat.full;
    assign b          = i_in_word.text_byte;
    assign plen_inc   = (r_plen == LEN_MAX) ? r_plen : r_plen + 1'b1;

    // Decision for a byte seen between tokens.
    always_comb begin
        il_emit              = 1'b0;
        il_begin             = 1'b0;
        il_mode              = M_IDLE;
        il_tok               = '0;
        il_tok.token_start   = r_pos;
        il_tok.token_length  = LENGTH_BITS'(1);
        il_tok.error_code    = ERR_NONE;
        if (!is_space(b)) begin
            case (b)
                CH_SEMI: il_mode = M_COMMENT;
                CH_LPAREN: begin
                    il_emit           = 1'b1;
                    il_tok.token_kind = KIND_LPAREN;
                end
                CH_RPAREN: begin
                    il_emit           = 1'b1;
                    il_tok.token_kind = KIND_RPAREN;
                end
                CH_LBRACE: begin
                    il_emit           = 1'b1;
                    il_tok.token_kind = KIND_LBRACE;
                end
                CH_RBRACE: begin
                    il_emit           = 1'b1;
                    il_tok.token_kind = KIND_RBRACE;
                end
                CH_QUOTE: begin
                    il_begin = 1'b1;
                    il_mode  = M_STRING;
                end
                default: begin
                    if (is_digit(b)) begin
                        il_begin = 1'b1;
                        il_mode  = M_NUMBER;
                    end else if (is_symbyte(b)) begin
                        il_begin = 1'b1;
                        il_mode  = M_SYMBOL;
                    end else begin
                        il_emit           = 1'b1;
                        il_tok.token_kind = KIND_ERROR;
                        il_tok.error_code = ERR_UNEXPECTED;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_mode             = r_mode;
        n_pos              = r_pos + 1'b1;
        n_pstart           = r_pstart;
        n_plen             = r_plen;
        use_idle           = 1'b0;
        f_valid            = 1'b0;
        s_valid            = 1'b0;
        f_tok              = '0;
        f_tok.token_start  = r_pstart;
        f_tok.token_length = r_plen;
        f_tok.error_code   = ERR_NONE;
        s_tok              = '0;

        if (i_in_word.end_of_text) begin
            case (r_mode)
                M_NUMBER: begin
                    f_valid          = 1'b1;
                    f_tok.token_kind = KIND_NUMBER;
                end
                M_SYMBOL: begin
                    f_valid          = 1'b1;
                    f_tok.token_kind = KIND_SYMBOL;
                end
                M_STRING, M_STRESC: begin
                    f_valid          = 1'b1;
                    f_tok.token_kind = KIND_ERROR;
                    f_tok.error_code = ERR_UNTERM_STR;
                end
                default: f_valid = 1'b0;
            endcase
            s_valid            = 1'b1;
            s_tok.token_kind   = KIND_END;
            s_tok.token_start  = r_pos;
            s_tok.token_length = '0;
            s_tok.error_code   = ERR_NONE;
            n_mode             = M_IDLE;
            n_pos              = '0;
            n_pstart           = '0;
            n_plen             = '0;
        end else begin
            case (r_mode)
                M_COMMENT: begin
                    if (b == CH_LF) begin
                        n_mode = M_IDLE;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(b) || b == CH_DOT) begin
                        n_plen = plen_inc;
                    end else begin
                        f_valid          = 1'b1;
                        f_tok.token_kind = KIND_NUMBER;
                        use_idle         = 1'b1;
                    end
                end
                M_SYMBOL: begin
                    if (is_symbyte(b)) begin
                        n_plen = plen_inc;
                    end else begin
                        f_valid          = 1'b1;
                        f_tok.token_kind = KIND_SYMBOL;
                        use_idle         = 1'b1;
                    end
                end
                M_STRING: begin
                    n_plen = plen_inc;
                    if (b == CH_QUOTE) begin
                        f_valid            = 1'b1;
                        f_tok.token_kind   = KIND_STRING;
                        f_tok.token_length = plen_inc;
                        n_mode             = M_IDLE;
                    end else if (b == CH_BSLASH) begin
                        n_mode = M_STRESC;
                    end
                end
                M_STRESC: begin
                    n_plen = plen_inc;
                    n_mode = M_STRING;
                end
                default: use_idle = 1'b1;
            endcase
            if (use_idle) begin
                s_valid = il_emit;
                s_tok   = il_tok;
                n_mode  = il_mode;
                if (il_begin) begin
                    n_pstart = r_pos;
                    n_plen   = LENGTH_BITS'(1);
                end
            end
        end
    end

    // Pack the tokens of this word so that the first one always sits in slot zero.
    always_comb begin
        o_entry = '0;
        if (f_valid) begin
            o_entry.two           = s_valid;
            o_entry.tok0          = f_tok;
            o_entry.tok0.run_last = !s_valid;
            o_entry.tok1          = s_tok;
            o_entry.tok1.run_last = 1'b1;
        end else begin
            o_entry.two           = 1'b0;
            o_entry.tok0          = s_tok;
            o_entry.tok0.run_last = 1'b1;
            o_entry.tok1          = s_tok;
            o_entry.tok1.run_last = 1'b1;
        end
        o_push = accept && (f_valid || s_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_pstart <= '0;
            r_plen   <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
        end
    end

`ifndef SYNTH
    // An end word returns the lexer to its reset state.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_word.end_of_text |=> r_mode == M_IDLE && r_pos == '0 && r_plen == '0)
        else $error("lexer state not cleared after end of text");

    // Every ordinary byte advances the offset by one.
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_in_word.end_of_text |=> r_pos == $past(r_pos) + 1'b1)
        else $error("byte offset did not advance");
`endif

endmodule

`default_nettype wire

### design/llex_queue.sv
// Short queue of token entries between the lexer front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module llex_queue import llex_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_head,
    output t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full || i_pop)
        else $error("word pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("word popped from an empty queue");
`endif

endmodule

`default_nettype wire

### design/llex_back.sv
// Back end: unpacks queued entries into single token words behind an output register.
`timescale 1ns / 1ps
`default_nettype none

module llex_back import llex_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic      r_valid, n_valid;
    logic      r_second, n_second;
    t_out_word r_word, n_word;
    logic      load;

    assign load        = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_word   = r_word;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = !i_q_stat.empty;
            if (!i_q_stat.empty) begin
                n_word   = r_second ? i_head.tok1 : i_head.tok0;
                o_pop    = r_second || !i_head.two;
                n_second = i_head.two && !r_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

`ifndef SYNTH
    // The second half of an entry is only pending while that entry is still queued.
    a_second_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> !i_q_stat.empty && i_head.two)
        else $error("second token pending without a two-token entry");
`endif

endmodule

`default_nettype wire

### design/lisp_token_lexer_core.sv
// Top level of the streaming s-expression token lexer.
//
//   Channel | Direction | Handshake                    | Word
//   --------+-----------+------------------------------+------------------------
//   in      | to core   | i_in_valid / o_in_stall      | i_in_word  (t_in_word)
//   out     | from core | o_out_valid / i_out_stall    | o_out_word (t_out_word)
//
// One source word is accepted per cycle while the token queue has room.
// The output register moves one token per cycle while i_out_stall is low, so a word that yields two
// tokens holds its queue entry until both have left, and a run of such words fills the queue and slows the input.
// The first token of a word reaches the output through the queue and then the output register.
// Reset is synchronous and active low; it empties the queue and returns the lexer to idle.
// Input stall rises only when the QUEUE_DEPTH entry queue is full.
`timescale 1ns / 1ps
`default_nettype none

module lisp_token_lexer_core import llex_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_q_stat q_stat;
    t_entry  push_entry, head_entry;
    logic    push, pop;

    llex_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_q_stat   (q_stat),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    llex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_stat  (q_stat)
    );

    llex_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_entry),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

### tb/lisp_token_lexer_core_test.sv
// Self-checking testbench for the s-expression token lexer, with its own token predictor.
`timescale 1ns / 1ps

module lisp_token_lexer_core_test;
    import llex_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD = 80;
    localparam int RANDOM_WORDS = 870;
    localparam logic [8*18-1:0] PUNCT = "!$%&*/:<=>?@^_~+-\\";

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_COMMENT, SCAN_NUMBER, SCAN_SYMBOL, SCAN_STRING, SCAN_ESCAPE
    } t_scan_mode;

    typedef enum logic [1:0] {CLS_SPACE, CLS_DIGIT, CLS_SYMBOL, CLS_OTHER} t_class;

    typedef struct {
        logic [7:0] text_byte;
        logic       end_of_text;
        int         n_typed;
        t_out_word  want0;
        t_out_word  want1;
    } t_plan_row;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    t_scan_mode             scan_mode = SCAN_IDLE;
    logic [OFFSET_BITS-1:0] scan_pos = '0;
    logic [OFFSET_BITS-1:0] tok_start = '0;
    logic [LENGTH_BITS-1:0] tok_len = '0;
    t_out_word              word_tokens[$];
    t_out_word              tokens_due[$];
    t_plan_row              plan[$];

    int faults = 0;
    int idle_cycles = 0;
    int sink_gap = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int lexed_words = 0;
    bit quiet_flow = 1'b0;

    lisp_token_lexer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_out_word tok(input logic [3:0] kind, input logic [OFFSET_BITS-1:0] start,
                                      input logic [LENGTH_BITS-1:0] len, input logic [1:0] code,
                                      input logic last);
        t_out_word t;
        t.token_kind   = kind;
        t.token_start  = start;
        t.token_length = len;
        t.error_code   = code;
        t.run_last     = last;
        return t;
    endfunction

    function automatic t_class classify(input logic [7:0] b);
        int k;
        if (b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D)) return CLS_SPACE;
        if (b >= "0" && b <= "9") return CLS_DIGIT;
        if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) return CLS_SYMBOL;
        for (k = 0; k < 18; k++) begin
            if (PUNCT[8*k +: 8] == b) return CLS_SYMBOL;
        end
        return CLS_OTHER;
    endfunction

    function automatic void open_token(input t_scan_mode mode);
        scan_mode = mode;
        tok_start = scan_pos;
        tok_len   = 1;
    endfunction

    function automatic void lengthen();
        if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
    endfunction

    // Lexes a byte as if no token were pending.
    function automatic void lex_fresh(input logic [7:0] b);
        scan_mode = SCAN_IDLE;
        case (b)
            CH_SEMI:   scan_mode = SCAN_COMMENT;
            CH_LPAREN: word_tokens.push_back(tok(KIND_LPAREN, scan_pos, 1, ERR_NONE, 1'b0));
            CH_RPAREN: word_tokens.push_back(tok(KIND_RPAREN, scan_pos, 1, ERR_NONE, 1'b0));
            CH_LBRACE: word_tokens.push_back(tok(KIND_LBRACE, scan_pos, 1, ERR_NONE, 1'b0));
            CH_RBRACE: word_tokens.push_back(tok(KIND_RBRACE, scan_pos, 1, ERR_NONE, 1'b0));
            CH_QUOTE:  open_token(SCAN_STRING);
            default: begin
                case (classify(b))
                    CLS_SPACE:  ;
                    CLS_DIGIT:  open_token(SCAN_NUMBER);
                    CLS_SYMBOL: open_token(SCAN_SYMBOL);
                    default: word_tokens.push_back(tok(KIND_ERROR, scan_pos, 1,
                                                       ERR_UNEXPECTED, 1'b0));
                endcase
            end
        endcase
    endfunction

    function automatic void predict_word(input t_in_word w);
        t_class c;
        word_tokens.delete();
        c = classify(w.text_byte);
        if (w.end_of_text) begin
            case (scan_mode)
                SCAN_NUMBER: word_tokens.push_back(tok(KIND_NUMBER, tok_start, tok_len,
                                                       ERR_NONE, 1'b0));
                SCAN_SYMBOL: word_tokens.push_back(tok(KIND_SYMBOL, tok_start, tok_len,
                                                       ERR_NONE, 1'b0));
                SCAN_STRING, SCAN_ESCAPE:
                    word_tokens.push_back(tok(KIND_ERROR, tok_start, tok_len,
                                              ERR_UNTERM_STR, 1'b0));
                default: ;
            endcase
            word_tokens.push_back(tok(KIND_END, scan_pos, 0, ERR_NONE, 1'b0));
            scan_mode = SCAN_IDLE;
            scan_pos  = '0;
            tok_start = '0;
            tok_len   = '0;
        end else begin
            case (scan_mode)
                SCAN_COMMENT: begin
                    if (w.text_byte == CH_LF) scan_mode = SCAN_IDLE;
                end
                SCAN_NUMBER: begin
                    if (c == CLS_DIGIT || w.text_byte == CH_DOT) begin
                        lengthen();
                    end else begin
                        word_tokens.push_back(tok(KIND_NUMBER, tok_start, tok_len,
                                                  ERR_NONE, 1'b0));
                        lex_fresh(w.text_byte);
                    end
                end
                SCAN_SYMBOL: begin
                    if (c == CLS_DIGIT || c == CLS_SYMBOL) begin
                        lengthen();
                    end else begin
                        word_tokens.push_back(tok(KIND_SYMBOL, tok_start, tok_len,
                                                  ERR_NONE, 1'b0));
                        lex_fresh(w.text_byte);
                    end
                end
                SCAN_STRING: begin
                    lengthen();
                    if (w.text_byte == CH_QUOTE) begin
                        word_tokens.push_back(tok(KIND_STRING, tok_start, tok_len,
                                                  ERR_NONE, 1'b0));
                        scan_mode = SCAN_IDLE;
                    end else if (w.text_byte == CH_BSLASH) begin
                        scan_mode = SCAN_ESCAPE;
                    end
                end
                SCAN_ESCAPE: begin
                    lengthen();
                    scan_mode = SCAN_STRING;
                end
                default: lex_fresh(w.text_byte);
            endcase
            scan_pos = scan_pos + 1'b1;
        end
        if (word_tokens.size() != 0) word_tokens[word_tokens.size()-1].run_last = 1'b1;
    endfunction

    task automatic send_word(input t_in_word w, input int n_typed,
                             input t_out_word want0, input t_out_word want1);
        int gap;
        gap = quiet_flow ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_word(w);
        if (n_typed >= 1) tokens_due.push_back(want0);
        if (n_typed >= 2) tokens_due.push_back(want1);
        if (n_typed == 0) begin
            foreach (word_tokens[k]) tokens_due.push_back(word_tokens[k]);
        end
        lexed_words++;
    endtask

    task automatic send_text(input logic [7:0] b, input logic eot);
        send_word(t_in_word'{b, eot}, 0, '0, '0);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tokens_due.size() != 0);
    endtask

    function automatic logic [7:0] symbol_byte();
        case ($urandom_range(0, 3))
            0: return "0" + 8'($urandom_range(0, 9));
            1: return "a" + 8'($urandom_range(0, 25));
            2: return "A" + 8'($urandom_range(0, 25));
            default: return PUNCT[8*$urandom_range(0, 17) +: 8];
        endcase
    endfunction

    function automatic logic [7:0] space_byte();
        return ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'h09 + 8'($urandom_range(0, 4));
    endfunction

    // Mostly well-formed tokens with random content, plus noise and cut-off texts.
    task automatic send_fragment(input bit allow_end);
        int pick;
        logic [7:0] c;
        pick = $urandom_range(0, 19);
        if (pick <= 3) begin
            case ($urandom_range(0, 3))
                0: send_text(CH_LPAREN, 1'b0);
                1: send_text(CH_RPAREN, 1'b0);
                2: send_text(CH_LBRACE, 1'b0);
                default: send_text(CH_RBRACE, 1'b0);
            endcase
        end else if (pick <= 6) begin
            send_text("0" + 8'($urandom_range(0, 9)), 1'b0);
            repeat ($urandom_range(0, 6)) begin
                c = ($urandom_range(0, 3) == 0) ? CH_DOT : "0" + 8'($urandom_range(0, 9));
                send_text(c, 1'b0);
            end
        end else if (pick <= 10) begin
            repeat ($urandom_range(1, 7)) send_text(symbol_byte(), 1'b0);
        end else if (pick <= 12 || pick == 17) begin
            send_text(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 8)) begin
                c = 8'($urandom_range(0, 255));
                send_text((c == CH_QUOTE) ? CH_BSLASH : c, 1'b0);
            end
            send_text((pick == 17 && allow_end) ? 8'($urandom_range(0, 255)) : CH_QUOTE,
                      pick == 17 && allow_end);
        end else if (pick == 13) begin
            send_text(CH_SEMI, 1'b0);
            repeat ($urandom_range(0, 6)) begin
                c = 8'($urandom_range(0, 255));
                send_text((c == CH_LF) ? CH_SPACE : c, 1'b0);
            end
            send_text(CH_LF, 1'b0);
        end else if (pick <= 15) begin
            repeat ($urandom_range(1, 3)) send_text(space_byte(), 1'b0);
        end else if (pick == 18 && allow_end) begin
            send_text(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            send_text(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    function automatic t_plan_row step_row(input logic [7:0] b, input logic eot, input int n,
                                           input t_out_word w0, input t_out_word w1);
        t_plan_row r;
        r.text_byte   = b;
        r.end_of_text = eot;
        r.n_typed     = n;
        r.want0       = w0;
        r.want1       = w1;
        return r;
    endfunction

    task automatic check_token(input t_out_word got);
        t_out_word want;
        if (tokens_due.size() == 0) begin
            faults++;
            if (faults <= 10)
                $display("Unexpected token: kind %0d start %0d length %0d code %0d last %0b",
                         got.token_kind, got.token_start, got.token_length, got.error_code,
                         got.run_last);
        end else begin
            want = tokens_due.pop_front();
            if (got.token_kind !== want.token_kind || got.token_start !== want.token_start ||
                got.token_length !== want.token_length ||
                got.error_code !== want.error_code || got.run_last !== want.run_last) begin
                faults++;
                if (faults <= 10)
                    $display("Token mismatch: expected %0d/%0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0d/%0b",
                             want.token_kind, want.token_start, want.token_length,
                             want.error_code, want.run_last, got.token_kind, got.token_start,
                             got.token_length, got.error_code, got.run_last);
            end
        end
    endtask

    // Receiving side: random stalls between words, and one long hold on request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                check_token(o_out_word);
                sink_gap = quiet_flow ? 0 : $urandom_range(0, 5);
            end else if (sink_gap > 0) begin
                sink_gap--;
            end
            if (holds_served != holds_asked) begin
                holds_served++;
                sink_gap = LONG_HOLD;
            end
            i_out_stall <= (sink_gap > 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL lisp_token_lexer_core");
            $finish;
        end
    end

    initial begin
        plan.push_back(step_row(CH_LPAREN, 1'b0, 1, tok(KIND_LPAREN, 0, 1, ERR_NONE, 1'b1), '0));
        plan.push_back(step_row(CH_RPAREN, 1'b0, 1, tok(KIND_RPAREN, 1, 1, ERR_NONE, 1'b1), '0));
        plan.push_back(step_row(CH_LBRACE, 1'b0, 1, tok(KIND_LBRACE, 2, 1, ERR_NONE, 1'b1), '0));
        plan.push_back(step_row(CH_RBRACE, 1'b0, 1, tok(KIND_RBRACE, 3, 1, ERR_NONE, 1'b1), '0));
        plan.push_back(step_row(8'h00, 1'b0, 1, tok(KIND_ERROR, 4, 1, ERR_UNEXPECTED, 1'b1), '0));
        plan.push_back(step_row(8'hFF, 1'b0, 1, tok(KIND_ERROR, 5, 1, ERR_UNEXPECTED, 1'b1), '0));
        plan.push_back(step_row(CH_SPACE, 1'b0, 0, '0, '0));
        plan.push_back(step_row("1", 1'b0, 0, '0, '0));
        plan.push_back(step_row(CH_DOT, 1'b0, 0, '0, '0));
        plan.push_back(step_row("9", 1'b0, 0, '0, '0));
        plan.push_back(step_row("a", 1'b0, 0, '0, '0));
        plan.push_back(step_row("~", 1'b0, 0, '0, '0));
        plan.push_back(step_row(8'h80, 1'b0, 2, tok(KIND_SYMBOL, 10, 2, ERR_NONE, 1'b0),
                                tok(KIND_ERROR, 12, 1, ERR_UNEXPECTED, 1'b1)));
        plan.push_back(step_row(CH_QUOTE, 1'b0, 0, '0, '0));
        plan.push_back(step_row(CH_BSLASH, 1'b0, 0, '0, '0));
        plan.push_back(step_row(CH_QUOTE, 1'b0, 0, '0, '0));
        plan.push_back(step_row(CH_SEMI, 1'b0, 0, '0, '0));
        plan.push_back(step_row(CH_QUOTE, 1'b0, 0, '0, '0));
        plan.push_back(step_row("+", 1'b0, 0, '0, '0));
        plan.push_back(step_row(CH_LPAREN, 1'b0, 0, '0, '0));
        plan.push_back(step_row(CH_QUOTE, 1'b0, 0, '0, '0));
        plan.push_back(step_row("z", 1'b0, 0, '0, '0));
        plan.push_back(step_row(8'h5A, 1'b1, 2, tok(KIND_ERROR, 20, 2, ERR_UNTERM_STR, 1'b0),
                                tok(KIND_END, 22, 0, ERR_NONE, 1'b1)));
        plan.push_back(step_row(8'hA5, 1'b1, 1, tok(KIND_END, 0, 0, ERR_NONE, 1'b1), '0));
        plan.push_back(step_row(CH_SEMI, 1'b0, 0, '0, '0));
        plan.push_back(step_row(8'h00, 1'b1, 1, tok(KIND_END, 1, 0, ERR_NONE, 1'b1), '0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k])
            send_word(t_in_word'{plan[k].text_byte, plan[k].end_of_text}, plan[k].n_typed,
                      plan[k].want0, plan[k].want1);
        drain();

        // Random texts, with one long output hold and input pauses that drain the queue around word 600.
        lexed_words = 0;
        while (lexed_words < RANDOM_WORDS) begin
            quiet_flow = ((lexed_words / 100) % 3 == 2);
            if (holds_asked == 0 && lexed_words >= 300) begin
                quiet_flow = 1'b0;
                holds_asked++;
            end
            if (lexed_words >= 600 && lexed_words < 610) drain();
            send_fragment(1'b1);
        end
        send_text(8'($urandom_range(0, 255)), 1'b1);
        quiet_flow = 1'b0;

        drain();
        repeat (20) @(posedge i_clk);
        if (faults == 0 && tokens_due.size() == 0)
            $display("PASS lisp_token_lexer_core");
        else
            $display("FAIL lisp_token_lexer_core");
        $finish;
    end

endmodule
